// ===== rtl/core/acct_pkg.sv =====
// Shared types, constants and shape decode for the collider pair test.
package acct_pkg;

  localparam int COORD_BITS = 16;
  localparam int SIZE_BITS  = COORD_BITS - 1;
  localparam int XW         = COORD_BITS + 2;   // doubled edges and centers
  localparam int DW         = XW + 1;           // differences, radius sum
  localparam int SW         = 2 * DW;           // squares
  localparam int LATENCY    = 4;

  typedef enum logic [1:0] {
    KIND_BOX    = 2'd0,
    KIND_CIRCLE = 2'd1,
    KIND_OTHER0 = 2'd2,
    KIND_OTHER1 = 2'd3
  } kind_t;

  typedef logic signed [XW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;
  typedef logic signed [SW-1:0] sq_t;
  typedef logic signed [SW:0]   sqsum_t;

  typedef struct packed {
    logic   active;
    kind_t  kind;
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
    coord_t cx;
    coord_t cy;
    coord_t r;
  } shape_t;

  // control that rides along with the distance test
  typedef struct packed {
    logic valid;
    logic pre_hit;
    logic use_dist;
  } ctl_t;

  function automatic shape_t load_shape(
    input logic                         active,
    input logic [1:0]                   kind,
    input logic signed [COORD_BITS-1:0] left,
    input logic signed [COORD_BITS-1:0] top,
    input logic [SIZE_BITS-1:0]         width,
    input logic [SIZE_BITS-1:0]         height
  );
    shape_t s;
    coord_t w1, h1;
    s.active = active;
    s.kind   = kind_t'(kind);
    w1       = {3'b000, width};
    h1       = {3'b000, height};
    s.x0     = {left[COORD_BITS-1], left, 1'b0};
    s.y0     = {top[COORD_BITS-1], top, 1'b0};
    s.x1     = s.x0 + (w1 <<< 1);
    s.y1     = s.y0 + (h1 <<< 1);
    s.cx     = s.x0 + w1;
    s.cy     = s.y0 + h1;
    s.r      = w1;
    return s;
  endfunction

  function automatic coord_t clamp_c(input coord_t v, input coord_t lo, input coord_t hi);
    coord_t c;
    if (v < lo) begin
      c = lo;
    end else if (v > hi) begin
      c = hi;
    end else begin
      c = v;
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/acct_dist_cmp.sv =====
// Two-stage squared distance against squared radius compare.
module acct_dist_cmp
  import acct_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  ctl_t  ctl_in,
  input  diff_t dx,
  input  diff_t dy,
  input  diff_t rad,
  output logic  out_valid,
  output logic  out_hit
);

  sq_t  dx_sq, dy_sq, rad_sq;
  ctl_t ctl_q;

  always_ff @(posedge clk) begin
    dx_sq  <= sq_t'(dx) * sq_t'(dx);
    dy_sq  <= sq_t'(dy) * sq_t'(dy);
    rad_sq <= sq_t'(rad) * sq_t'(rad);
    if (rst) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_in;
    end
  end

  sqsum_t dist_sq;
  logic   less;

  assign dist_sq = sqsum_t'(dx_sq) + sqsum_t'(dy_sq);
  assign less    = dist_sq < sqsum_t'(rad_sq);

  always_ff @(posedge clk) begin
    out_hit <= ctl_q.pre_hit | (ctl_q.use_dist & less);
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= ctl_q.valid;
    end
  end

endmodule

// ===== rtl/core/aabb_circle_collision_test.sv =====
// Collider pair test: box/circle overlap of two colliders, one item per cycle.
// Hit and done are registered at the end of the pipeline that start enters.
// Throughput: one item per cycle; busy is always low, four items may be in flight.
// Stages: decode, overlap/clamp/difference, squaring multipliers, sum and compare.
// Reset clears the stage valid bits only; results are not held off by the receiver.
module aabb_circle_collision_test
  import acct_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         first_active,
  input  logic [1:0]                   first_kind,
  input  logic signed [COORD_BITS-1:0] first_left,
  input  logic signed [COORD_BITS-1:0] first_top,
  input  logic [SIZE_BITS-1:0]         first_width,
  input  logic [SIZE_BITS-1:0]         first_height,
  input  logic                         second_active,
  input  logic [1:0]                   second_kind,
  input  logic signed [COORD_BITS-1:0] second_left,
  input  logic signed [COORD_BITS-1:0] second_top,
  input  logic [SIZE_BITS-1:0]         second_width,
  input  logic [SIZE_BITS-1:0]         second_height,
  output logic                         done,
  output logic                         hit
);

  assign busy = 1'b0;

  // stage 1: decode both colliders
  logic   s1_valid;
  shape_t sa, sb;

  always_ff @(posedge clk) begin
    sa <= load_shape(first_active, first_kind, first_left, first_top,
                     first_width, first_height);
    sb <= load_shape(second_active, second_kind, second_left, second_top,
                     second_width, second_height);
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start & ~busy;
    end
  end

  // stage 2: overlap, pair type, clamp and differences
  coord_t il, ir, it, ib, nx, ny;
  logic   overlap, both_act, pair_bb, pair_cc, pair_bc, pair_cb, in_box;
  shape_t bx, cr;
  diff_t  dx_n, dy_n, rad_n;
  ctl_t   ctl_n, ctl_q;
  diff_t  dx_q, dy_q, rad_q;

  always_comb begin
    il       = (sa.x0 > sb.x0) ? sa.x0 : sb.x0;
    ir       = (sa.x1 < sb.x1) ? sa.x1 : sb.x1;
    it       = (sa.y0 > sb.y0) ? sa.y0 : sb.y0;
    ib       = (sa.y1 < sb.y1) ? sa.y1 : sb.y1;
    overlap  = (il < ir) && (it < ib);
    both_act = sa.active & sb.active;
    pair_bb  = (sa.kind == KIND_BOX) && (sb.kind == KIND_BOX);
    pair_cc  = (sa.kind == KIND_CIRCLE) && (sb.kind == KIND_CIRCLE);
    pair_bc  = (sa.kind == KIND_BOX) && (sb.kind == KIND_CIRCLE);
    pair_cb  = (sa.kind == KIND_CIRCLE) && (sb.kind == KIND_BOX);
    bx       = pair_bc ? sa : sb;
    cr       = pair_bc ? sb : sa;
    in_box   = (cr.cx >= bx.x0) && (cr.cx < bx.x1) &&
               (cr.cy >= bx.y0) && (cr.cy < bx.y1);
    nx       = clamp_c(cr.cx, bx.x0, bx.x1);
    ny       = clamp_c(cr.cy, bx.y0, bx.y1);
    if (pair_cc) begin
      dx_n  = diff_t'(sa.cx) - diff_t'(sb.cx);
      dy_n  = diff_t'(sa.cy) - diff_t'(sb.cy);
      rad_n = diff_t'(sa.r) + diff_t'(sb.r);
    end else begin
      dx_n  = diff_t'(nx) - diff_t'(cr.cx);
      dy_n  = diff_t'(ny) - diff_t'(cr.cy);
      rad_n = diff_t'(cr.r);
    end
    ctl_n.valid    = s1_valid;
    ctl_n.pre_hit  = both_act & overlap & (pair_bb | ((pair_bc | pair_cb) & in_box));
    ctl_n.use_dist = both_act & overlap & (pair_cc | pair_bc | pair_cb);
  end

  always_ff @(posedge clk) begin
    dx_q  <= dx_n;
    dy_q  <= dy_n;
    rad_q <= rad_n;
    if (rst) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_n;
    end
  end

  // stages 3 and 4: squares, sum and compare
  acct_dist_cmp u_dist (
    .clk       (clk),
    .rst       (rst),
    .ctl_in    (ctl_q),
    .dx        (dx_q),
    .dy        (dy_q),
    .rad       (rad_q),
    .out_valid (done),
    .out_hit   (hit)
  );

  // no reset while the checked item passed through the pipeline
  a_latency: assert property (@(posedge clk)
    (!$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3) && !$past(rst, LATENCY))
    |-> (done == $past(start, LATENCY)))
    else $error("done does not follow start by the pipeline latency");

  a_inactive: assert property (@(posedge clk)
    (done && !$past(first_active & second_active, LATENCY)) |-> !hit)
    else $error("hit reported for an inactive collider");

  a_other_kind: assert property (@(posedge clk)
    (done && ($past(first_kind[1], LATENCY) || $past(second_kind[1], LATENCY)))
    |-> !hit)
    else $error("hit reported for an unsupported shape kind");

endmodule
